@@ rtl/rtp_header_parser_macros.svh @@
`ifndef RTP_HEADER_PARSER_MACROS_SVH
`define RTP_HEADER_PARSER_MACROS_SVH

// same-cycle implication, sampled on clk, off during reset
`define RHP_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk, off during reset
`define RHP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/rhp_pkg.sv @@
`timescale 1ns / 1ps

package rhp_pkg;

  localparam int unsigned CNT_W = 16;

  localparam logic [1:0]  RTP_VERSION   = 2'd2;
  localparam logic [15:0] MIN_HDR_BYTES = 16'd12;
  localparam logic [6:0]  EXT_LEN_OFS   = 7'd14;
  localparam logic [3:0]  SEQ_END       = 4'd4;
  localparam logic [3:0]  TS_END        = 4'd8;
  localparam logic [3:0]  SSRC_END      = 4'd12;

  typedef enum logic [1:0] {
    STATUS_OK        = 2'd0,
    STATUS_PARSE_ERR = 2'd1,
    STATUS_TOO_LONG  = 2'd2
  } status_t;

  typedef struct packed {
    logic [CNT_W-1:0] len;
    logic [7:0]       b0;
    logic [7:0]       b1;
    logic [15:0]      seq;
    logic [31:0]      ts;
    logic [31:0]      ssrc;
    logic [15:0]      ext_words;
    logic             overflow;
  } hdr_t;

  typedef struct packed {
    status_t     status;
    logic        marker;
    logic [6:0]  pay_type;
    logic [15:0] seq;
    logic [31:0] ts;
    logic [31:0] ssrc;
    logic [3:0]  src_count;
    logic        has_ext;
    logic        has_pad;
    logic [15:0] hdr_size;
    logic [15:0] pay_size;
  } result_t;

endpackage

@@ rtl/rtp_header_parser.sv @@
// RTP fixed header parser.
// Input channel: one packet byte per item (in_data_byte), network order, with
// in_last_byte set on the final byte of the packet. Bytes are taken on
// in_valid & in_ready; payload bytes are counted but not passed on.
// Result channel: one item per packet, shown on out_valid after the final
// byte, holding status, header fields and header/payload sizes. On any error
// status is non-zero and all other fields read zero.
// Result is registered: it shows in the cycle after the final byte is taken.
// Throughput: one byte per cycle while in_ready is high; the parse is a
// single pass of logic between the capture registers and the result register.
// Stall: while a result waits for out_ready, in_ready stays high only if
// the result is taken in the same cycle, so no result is ever overwritten.
// Packets longer than MAX_PACKET_BYTES hold the count at the limit, drop
// the extra bytes and give a too-long status.
// Reset: synchronous active-low rst_n clears the byte count and captured
// fields and empties the result register.
`timescale 1ns / 1ps

module rtp_header_parser #(
  parameter int unsigned MAX_PACKET_BYTES = 2048
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_data_byte,
  input  logic        in_last_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_status,
  output logic        out_marker,
  output logic [6:0]  out_pay_type,
  output logic [15:0] out_seq_num,
  output logic [31:0] out_timestamp,
  output logic [31:0] out_ssrc,
  output logic [3:0]  out_src_count,
  output logic        out_ext_flag,
  output logic        out_pad_flag,
  output logic [15:0] out_hdr_bytes,
  output logic [15:0] out_pay_bytes
);

  `include "rtp_header_parser_macros.svh"

  rhp_pkg::hdr_t    snap;
  rhp_pkg::result_t res_nxt;
  rhp_pkg::result_t res_r;
  logic             out_valid_r;
  logic             in_fire;

  assign in_ready = !out_valid_r || out_ready;
  assign in_fire  = in_valid && in_ready;

  rhp_capture #(
    .MaxBytes (MAX_PACKET_BYTES)
  ) u_capture (
    .clk       (clk),
    .rst_n     (rst_n),
    .fire      (in_fire),
    .data_byte (in_data_byte),
    .last_byte (in_last_byte),
    .snap      (snap)
  );

  rhp_check u_check (
    .hdr        (snap),
    .final_byte (in_data_byte),
    .res        (res_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_fire && in_last_byte) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire && in_last_byte) begin
      res_r <= res_nxt;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_status    = res_r.status;
  assign out_marker    = res_r.marker;
  assign out_pay_type  = res_r.pay_type;
  assign out_seq_num   = res_r.seq;
  assign out_timestamp = res_r.ts;
  assign out_ssrc      = res_r.ssrc;
  assign out_src_count = res_r.src_count;
  assign out_ext_flag  = res_r.has_ext;
  assign out_pad_flag  = res_r.has_pad;
  assign out_hdr_bytes = res_r.hdr_size;
  assign out_pay_bytes = res_r.pay_size;

  `RHP_ASSERT_NEXT(a_last_gives_item, in_fire && in_last_byte, out_valid_r,
    "final byte taken but no result item")
  `RHP_ASSERT_NEXT(a_no_spurious_item, in_fire && !in_last_byte && (!out_valid_r || out_ready),
    !out_valid_r, "result item without a final byte")
  `RHP_ASSERT_SAME(a_err_sizes_zero,
    out_valid_r && res_r.status != rhp_pkg::STATUS_OK,
    res_r.hdr_size == 16'd0 && res_r.pay_size == 16'd0, "error item with non-zero sizes")
  `RHP_ASSERT_SAME(a_ok_min_header, out_valid_r && res_r.status == rhp_pkg::STATUS_OK,
    res_r.hdr_size >= rhp_pkg::MIN_HDR_BYTES, "good item with header under minimum")

endmodule

@@ rtl/rhp_capture.sv @@
`timescale 1ns / 1ps

module rhp_capture #(
  parameter int unsigned MaxBytes = 2048
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        fire,
  input  logic [7:0]  data_byte,
  input  logic        last_byte,
  output rhp_pkg::hdr_t snap
);

  rhp_pkg::hdr_t cur_r;
  rhp_pkg::hdr_t cur_nxt;
  logic [6:0]    ext_at;
  logic [rhp_pkg::CNT_W-1:0] pos;

  assign pos    = cur_r.len;
  assign ext_at = rhp_pkg::EXT_LEN_OFS + {1'b0, cur_r.b0[3:0], 2'b00};

  always_comb begin
    cur_nxt = cur_r;
    if (cur_r.len < rhp_pkg::CNT_W'(MaxBytes)) begin
      cur_nxt.len = cur_r.len + rhp_pkg::CNT_W'(1);
      if (pos == '0) begin
        cur_nxt.b0 = data_byte;
      end else if (pos == rhp_pkg::CNT_W'(1)) begin
        cur_nxt.b1 = data_byte;
      end else if (pos < rhp_pkg::CNT_W'(rhp_pkg::SEQ_END)) begin
        cur_nxt.seq = {cur_r.seq[7:0], data_byte};
      end else if (pos < rhp_pkg::CNT_W'(rhp_pkg::TS_END)) begin
        cur_nxt.ts = {cur_r.ts[23:0], data_byte};
      end else if (pos < rhp_pkg::CNT_W'(rhp_pkg::SSRC_END)) begin
        cur_nxt.ssrc = {cur_r.ssrc[23:0], data_byte};
      end
      // extension length field sits two bytes past the csrc list
      if (pos >= rhp_pkg::CNT_W'(rhp_pkg::SSRC_END) &&
          (pos == rhp_pkg::CNT_W'(ext_at) ||
           pos == rhp_pkg::CNT_W'(ext_at) + rhp_pkg::CNT_W'(1))) begin
        cur_nxt.ext_words = {cur_r.ext_words[7:0], data_byte};
      end
    end else begin
      cur_nxt.overflow = 1'b1;
    end
  end

  assign snap = cur_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_r <= '0;
    end else if (fire) begin
      if (last_byte) begin
        cur_r <= '0;
      end else begin
        cur_r <= cur_nxt;
      end
    end
  end

endmodule

@@ rtl/rhp_check.sv @@
`timescale 1ns / 1ps

module rhp_check (
  input  rhp_pkg::hdr_t   hdr,
  input  logic [7:0]      final_byte,
  output rhp_pkg::result_t res
);

  logic [18:0] len;
  logic [18:0] hs_base;
  logic [18:0] hs_full;
  logic [18:0] hs;
  logic [18:0] rem;
  logic [18:0] pad;
  logic [18:0] pay;
  logic        has_ext;
  logic        has_pad;
  logic        err;

  assign has_ext = hdr.b0[4];
  assign has_pad = hdr.b0[5];
  assign len     = {3'b000, hdr.len};
  assign hs_base = 19'd12 + {13'd0, hdr.b0[3:0], 2'b00};
  assign hs_full = hs_base + 19'd4 + {1'b0, hdr.ext_words, 2'b00};
  assign hs      = has_ext ? hs_full : hs_base;
  assign rem     = len - hs;
  assign pad     = has_pad ? {11'd0, final_byte} : '0;
  assign pay     = rem - pad;

  always_comb begin
    err = 1'b0;
    if (hdr.len < rhp_pkg::MIN_HDR_BYTES) begin
      err = 1'b1;
    end else if (hdr.b0[7:6] != rhp_pkg::RTP_VERSION) begin
      err = 1'b1;
    end else if (len < hs_base) begin
      err = 1'b1;
    end else if (has_ext && (len < hs_base + 19'd4 || len < hs_full)) begin
      err = 1'b1;
    end else if (has_pad && (final_byte == 8'd0 || pad > rem)) begin
      err = 1'b1;
    end
  end

  always_comb begin
    res = '0;
    if (hdr.overflow) begin
      res.status = rhp_pkg::STATUS_TOO_LONG;
    end else if (err) begin
      res.status = rhp_pkg::STATUS_PARSE_ERR;
    end else begin
      res.status     = rhp_pkg::STATUS_OK;
      res.marker     = hdr.b1[7];
      res.pay_type   = hdr.b1[6:0];
      res.seq        = hdr.seq;
      res.ts         = hdr.ts;
      res.ssrc       = hdr.ssrc;
      res.src_count  = hdr.b0[3:0];
      res.has_ext    = has_ext;
      res.has_pad    = has_pad;
      res.hdr_size   = hs[15:0];
      res.pay_size   = pay[15:0];
    end
  end

endmodule
